@@ sv/ftx_pkg.sv @@
// Shared types and constants for the FIFO-fed serial transmitter.
`timescale 1ns / 1ps
package ftx_pkg;

    localparam int DEFAULT_FIFO_DEPTH = 32;

    // Phase value that marks the transmitter idle; a frame runs phases 0..9.
    localparam logic [3:0] FRAME_END  = 4'd10;
    localparam logic [3:0] LAST_DATA  = 4'd8;
    localparam int         COUNT_W    = 5;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    // One result item as it leaves the core.
    typedef struct packed {
        logic [COUNT_W-1:0] fifo_count;
        logic               busy_res;
        logic               dropped;
        logic               line_level;
    } result_t;

endpackage

@@ sv/ftx_ram.sv @@
// Byte store of the transmit FIFO: one write port, one registered read port.
`timescale 1ns / 1ps
module ftx_ram
    import ftx_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_FIFO_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/ftx_core.sv @@
// FIFO pointers, frame sequencer and shift register of the serial transmitter.
`timescale 1ns / 1ps
module ftx_core
    import ftx_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH,
    parameter int PTR_W      = $clog2(FIFO_DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  cmd_t             command,
    input  logic [7:0]       data_byte,
    output result_t          result,
    output logic             wr_en,
    output logic [PTR_W-1:0] wr_addr,
    output logic [7:0]       wr_data,
    output logic             rd_en,
    output logic [PTR_W-1:0] rd_addr,
    input  logic [7:0]       rd_data
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(FIFO_DEPTH);

    logic [PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [7:0]       shift_reg, shift_next, cur_shift;
    logic [3:0]       phase_reg, phase_next;
    logic             line_reg, line_next;
    logic             load_pend_reg, load_pend_next;

    logic [PTR_W-1:0] wp_inc, rp_inc;
    logic             full, empty, drop;
    logic [PTR_W:0]   diff, fill;
    logic [PTR_W+COUNT_W:0] fill_ext;

    assign wp_inc = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
    assign full   = (wp_inc == rp_reg);
    assign empty  = (wp_reg == rp_reg);

    // Byte fetched by the last dequeue arrives from the registered read in the cycle after; take it here.
    assign cur_shift = load_pend_reg ? rd_data : shift_reg;

    assign wr_addr = wp_reg;
    assign wr_data = data_byte;
    assign rd_addr = rp_reg;

    always_comb begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        shift_next     = cur_shift;
        phase_next     = phase_reg;
        line_next      = line_reg;
        load_pend_next = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        drop           = 1'b0;
        if (accept) begin
            if (command == CMD_PUSH) begin
                if (!full) begin
                    wr_en   = 1'b1;
                    wp_next = wp_inc;
                end else begin
                    drop = 1'b1;
                end
            end else if (phase_reg < FRAME_END) begin
                if (phase_reg == 4'd0) begin
                    line_next = 1'b0;
                end else if (phase_reg <= LAST_DATA) begin
                    line_next  = cur_shift[0];
                    shift_next = {1'b0, cur_shift[7:1]};
                end else begin
                    line_next = 1'b1;
                end
                phase_next = phase_reg + 4'd1;
            end else if (!empty) begin
                rd_en          = 1'b1;
                rp_next        = rp_inc;
                phase_next     = 4'd0;
                load_pend_next = 1'b1;
            end else begin
                line_next  = 1'b1;
                phase_next = FRAME_END;
            end
        end
    end

    // Fill level after this item, reported modulo 32.
    always_comb begin
        diff     = {1'b0, wp_next} - {1'b0, rp_next};
        fill     = (wp_next >= rp_next) ? diff : diff + DEPTH_X;
        fill_ext = {{COUNT_W{1'b0}}, fill};
    end

    always_comb begin
        result.line_level = line_next;
        result.dropped    = drop;
        result.busy_res   = (phase_next < FRAME_END);
        result.fifo_count = fill_ext[COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            shift_reg     <= '0;
            phase_reg     <= FRAME_END;
            line_reg      <= 1'b1;
            load_pend_reg <= 1'b0;
        end else begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            shift_reg     <= shift_next;
            phase_reg     <= phase_next;
            line_reg      <= line_next;
            load_pend_reg <= load_pend_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A fetched byte lands while the frame sits at its start bit.
    a_load_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        load_pend_reg |-> (phase_reg == 4'd0))
        else $error("shift load outside start phase");
    a_rd_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !empty)
        else $error("dequeue from empty FIFO");
    a_wr_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !full && !drop)
        else $error("enqueue into full FIFO");
    a_dequeue_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> load_pend_reg && (phase_reg == 4'd0))
        else $error("dequeue did not start a frame");
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= FRAME_END)
        else $error("frame phase out of range");
`endif

endmodule

@@ sv/fifo_serial_transmitter.sv @@
// Top level of the FIFO-fed 8N1 serial transmitter with stream ports.
`timescale 1ns / 1ps
// One transaction in, one result transaction out. A push enqueues a byte
// (dropped = 1 when the FIFO already holds FIFO_DEPTH-1 bytes); a tick
// advances the line by one bit time: an idle tick with data dequeues a byte,
// the following ten ticks send start, eight data bits LSB first, and stop.
// The block accepts one item per cycle while s_tready is high; each result
// enters the output register on acceptance, and s_tready stays high while
// that register is empty or being drained. The byte store is a RAM with a
// registered read; a dequeued byte is picked up by the shift register on the
// next cycle, so no stall is needed. No clearing pass runs after reset.
module fifo_serial_transmitter
    import ftx_pkg::*;
#(
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0] s_tuser,   // [0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] line_level, [1] dropped, [2] busy_res,
                                  // [7:3] fifo_count
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic             accept;
    result_t          result;
    logic             wr_en, rd_en;
    logic [PTR_W-1:0] wr_addr, rd_addr;
    logic [7:0]       wr_data, rd_data;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    cmd_t             command;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign command  = cmd_t'(s_tuser[0]);

    ftx_core #(
        .FIFO_DEPTH(FIFO_DEPTH),
        .PTR_W     (PTR_W)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .command  (command),
        .data_byte(s_tdata),
        .result   (result),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    ftx_ram #(
        .DEPTH (FIFO_DEPTH),
        .ADDR_W(PTR_W)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
